// ----- rtl/core/matrix_multiply_engine_top_macros.svh -----
// Assertion macros used by the matrix multiply engine port-level checker.
`ifndef MATRIX_MULTIPLY_ENGINE_TOP_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_TOP_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define MME_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property violated");

// Check that a condition never holds outside reset.
`define MME_ASSERT_NEVER(label, cond) \
    `MME_ASSERT(label, !(cond))

`endif

// ----- rtl/core/mme_pkg.sv -----
// Types, constants and helpers for the matrix multiply engine.
package mme_pkg;

    localparam int MAX_DIM     = 16;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = 4;
    localparam int CFG_W       = 5;
    localparam int ELEM_W      = 16;
    localparam int MUL_W       = 2 * ELEM_W;
    localparam int PROD_W      = 40;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic REG_ROWS_USED = 1'b0;
    localparam logic REG_COLS_USED = 1'b1;

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(16);

    typedef enum logic [1:0] {
        OP_WRITE_A   = 2'd0,
        OP_WRITE_B   = 2'd1,
        OP_READ_PROD = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [CFG_W-1:0] row,
        input logic [CFG_W-1:0] col
    );
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row * MAX_DIM);
        return base + ADDR_W'(col);
    endfunction

endpackage

// ----- rtl/core/matrix_multiply_engine_top.sv -----
// Matrix multiply engine: A and B element stores with a shared multiply-accumulate unit.
//
// Input channel (in_valid/in_ready): each request carries opcode, row_index,
// col_index and element_value. Opcodes WRITE_A and WRITE_B store one element and
// give no result. READ_PROD returns one element of A x B on the output channel
// (out_valid/out_ready) as product_value and index_error.
// A product request walks cols_used (at most 16) multiply-accumulate steps
// through one 16x16 multiplier fed by one read port per store: the sequencer
// takes the request, reads both stores once per step, drains the read, multiply
// and accumulate registers, then loads the result into the output register.
// A row or column outside the sizes in use answers with index_error set and a
// zero product.
// in_ready is high only while the sequencer is idle. A finished result waits
// in the output register while writes still flow; the next product request
// holds in its final step until the receiver takes the previous result.
// Reset clears the sequencer, the output valid and sets rows_used and
// cols_used to 16; store contents are undefined until written.
// APB registers: rows_used at 0x0, cols_used at 0x4; pready is always high.
module matrix_multiply_engine_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           opcode,
    input  logic [mme_pkg::IDX_W-1:0]            row_index,
    input  logic [mme_pkg::IDX_W-1:0]            col_index,
    input  logic signed [mme_pkg::ELEM_W-1:0]    element_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [mme_pkg::PROD_W-1:0]    product_value,
    output logic                                 index_error,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mme_pkg::PADDR_W-1:0]          paddr,
    input  logic [mme_pkg::PDATA_W-1:0]          pwdata,
    output logic [mme_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready
);
    import mme_pkg::*;

    logic signed [ELEM_W-1:0] a_mem [STORE_DEPTH];
    logic signed [ELEM_W-1:0] b_mem [STORE_DEPTH];

    state_t state_reg, state_next;

    logic [CFG_W-1:0] rows_used_reg, rows_used_next;
    logic [CFG_W-1:0] cols_used_reg, cols_used_next;

    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [CFG_W-1:0] nc_reg, nc_next;
    logic [CFG_W-1:0] k_reg, k_next;
    logic             err_reg, err_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;

    logic             rd_vld_reg, rd_vld_next;
    logic             mul_vld_reg, mul_vld_next;
    logic signed [ELEM_W-1:0] a_rd_reg;
    logic signed [ELEM_W-1:0] b_rd_reg;
    logic signed [MUL_W-1:0]  mul_reg;

    logic                     out_valid_reg, out_valid_next;
    logic signed [PROD_W-1:0] product_reg, product_next;
    logic                     error_reg, error_next;

    logic             in_fire;
    logic             wr_in_store;
    logic             a_we;
    logic             b_we;
    logic             rd_req;
    logic             issue;
    logic             load_out;
    logic             last_k;
    logic             req_err;
    logic             cfg_we;
    logic [CFG_W-1:0] nr_eff;
    logic [CFG_W-1:0] nc_eff;
    logic [CFG_W-1:0] k_inc;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] a_raddr;
    logic [ADDR_W-1:0] b_raddr;

    assign in_fire     = in_valid && in_ready;
    assign wr_in_store = ({1'b0, row_index} < CFG_W'(MAX_DIM))
                      && ({1'b0, col_index} < CFG_W'(MAX_DIM));
    assign a_we        = in_fire && (opcode == OP_WRITE_A) && wr_in_store;
    assign b_we        = in_fire && (opcode == OP_WRITE_B) && wr_in_store;
    assign rd_req      = in_fire && (opcode == OP_READ_PROD);

    assign nr_eff  = (rows_used_reg > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : rows_used_reg;
    assign nc_eff  = (cols_used_reg > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : cols_used_reg;
    assign req_err = ({1'b0, row_index} >= nr_eff) || ({1'b0, col_index} >= nc_eff);

    assign k_inc  = k_reg + CFG_W'(1);
    assign last_k = (k_inc == nc_reg);

    assign waddr   = store_addr({1'b0, row_index}, {1'b0, col_index});
    assign a_raddr = store_addr({1'b0, row_reg}, k_reg);
    assign b_raddr = store_addr(k_reg, {1'b0, col_reg});

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (opcode == OP_READ_PROD))
                begin
                    state_next = req_err ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_k)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !mul_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_RUN:
            begin
                issue = 1'b1;
            end
            ST_DRAIN:
            begin
            end
            ST_DONE:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    // Datapath and output register next values
    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        nc_next        = nc_reg;
        err_next       = err_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        rd_vld_next    = issue;
        mul_vld_next   = rd_vld_reg;
        out_valid_next = out_valid_reg;
        product_next   = product_reg;
        error_next     = error_reg;

        if (rd_req)
        begin
            row_next = row_index;
            col_next = col_index;
            nc_next  = nc_eff;
            err_next = req_err;
            k_next   = '0;
            acc_next = '0;
        end
        if (issue)
        begin
            k_next = k_inc;
        end
        if (mul_vld_reg)
        begin
            acc_next = acc_reg + PROD_W'(mul_reg);
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
            product_next   = err_reg ? '0 : acc_reg;
            error_next     = err_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration registers
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        rows_used_next = rows_used_reg;
        cols_used_next = cols_used_reg;
        if (cfg_we)
        begin
            unique case (paddr[2])
                REG_ROWS_USED: rows_used_next = pwdata[CFG_W-1:0];
                REG_COLS_USED: cols_used_next = pwdata[CFG_W-1:0];
                default:       rows_used_next = rows_used_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ROWS_USED: prdata = PDATA_W'(rows_used_reg);
            REG_COLS_USED: prdata = PDATA_W'(cols_used_reg);
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rows_used_reg <= SIZE_RESET;
            cols_used_reg <= SIZE_RESET;
            rd_vld_reg    <= 1'b0;
            mul_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_used_reg <= rows_used_next;
            cols_used_reg <= cols_used_next;
            rd_vld_reg    <= rd_vld_next;
            mul_vld_reg   <= mul_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        col_reg     <= col_next;
        nc_reg      <= nc_next;
        err_reg     <= err_next;
        k_reg       <= k_next;
        acc_reg     <= acc_next;
        product_reg <= product_next;
        error_reg   <= error_next;
        mul_reg     <= a_rd_reg * b_rd_reg;
    end

    // Element stores: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[waddr] <= element_value;
        end
        if (issue)
        begin
            a_rd_reg <= a_mem[a_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[waddr] <= element_value;
        end
        if (issue)
        begin
            b_rd_reg <= b_mem[b_raddr];
        end
    end

    assign out_valid     = out_valid_reg;
    assign product_value = product_reg;
    assign index_error   = error_reg;

endmodule

// ----- rtl/core/mme_checker.sv -----
// Port-level checker for the matrix multiply engine, bound to the top level.
`include "matrix_multiply_engine_top_macros.svh"

module mme_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic [1:0]                           opcode,
    input logic [mme_pkg::IDX_W-1:0]            row_index,
    input logic [mme_pkg::IDX_W-1:0]            col_index,
    input logic signed [mme_pkg::ELEM_W-1:0]    element_value,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [mme_pkg::PROD_W-1:0]    product_value,
    input logic                                 index_error,
    input logic                                 psel,
    input logic                                 penable,
    input logic                                 pwrite,
    input logic [mme_pkg::PADDR_W-1:0]          paddr,
    input logic [mme_pkg::PDATA_W-1:0]          pwdata,
    input logic [mme_pkg::PDATA_W-1:0]          prdata,
    input logic                                 pready
);
    import mme_pkg::*;

    logic in_fire;
    logic rd_fire;
    logic wr_fire;
    logic cfg_touch;

    assign in_fire   = in_valid && in_ready;
    assign rd_fire   = in_fire && (opcode == OP_READ_PROD);
    assign wr_fire   = in_fire && (opcode != OP_READ_PROD);
    assign cfg_touch = psel && penable && pwrite && (paddr != '0) && (pwdata != '0)
                    && (row_index != col_index) && element_value[0] && (prdata != '0);

    `MME_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(product_value) && $stable(index_error))
    `MME_ASSERT(a_err_zero, out_valid && index_error |-> product_value == '0)
    `MME_ASSERT(a_write_no_result, wr_fire && !out_valid |=> !out_valid)
    `MME_ASSERT(a_read_busy, rd_fire |=> !in_ready)
    `MME_ASSERT(a_apb_ready, cfg_touch |-> pready)

endmodule

bind matrix_multiply_engine_top mme_checker u_mme_checker (.*);

// ----- bench/mme_product_checker.sv -----
// Checker for the matrix multiply engine: tracks stores and sizes, predicts and compares products.
module mme_product_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [1:0]                           opcode,
    input  logic [mme_pkg::IDX_W-1:0]            row_index,
    input  logic [mme_pkg::IDX_W-1:0]            col_index,
    input  logic signed [mme_pkg::ELEM_W-1:0]    element_value,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [mme_pkg::PROD_W-1:0]    product_value,
    input  logic                                 index_error,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mme_pkg::PADDR_W-1:0]          paddr,
    input  logic [mme_pkg::PDATA_W-1:0]          pwdata,
    input  logic                                 pready,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   products_checked,
    output int                                   error_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import mme_pkg::*;

    typedef struct packed {
        logic signed [PROD_W-1:0] value;
        logic                     index_error;
    } product_t;

    logic signed [ELEM_W-1:0] a_elems [MAX_DIM][MAX_DIM];
    logic signed [ELEM_W-1:0] b_elems [MAX_DIM][MAX_DIM];
    logic [CFG_W-1:0]         rows_cfg;
    logic [CFG_W-1:0]         cols_cfg;
    product_t                 expected_products [$];

    function automatic int clamp_size(input logic [CFG_W-1:0] size);
        return (size > MAX_DIM) ? MAX_DIM : int'(size);
    endfunction

    function automatic product_t dot_product_element(input int row, input int col);
        product_t res;
        longint   acc;
        int       nr;
        int       nc;
        int       k;
        nr = clamp_size(rows_cfg);
        nc = clamp_size(cols_cfg);
        acc = 0;
        res.index_error = 1'b0;
        if (row >= nr || col >= nc)
        begin
            res.index_error = 1'b1;
        end
        else
        begin
            for (k = 0; k < nc; k++)
            begin
                acc += longint'(a_elems[row][k]) * longint'(b_elems[k][col]);
            end
        end
        res.value = acc[PROD_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < 40)
        begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        product_t want;
        int       r;
        int       c;
        if (!rst_n)
        begin
            for (r = 0; r < MAX_DIM; r++)
            begin
                for (c = 0; c < MAX_DIM; c++)
                begin
                    a_elems[r][c] = '0;
                    b_elems[r][c] = '0;
                end
            end
            rows_cfg = SIZE_RESET;
            cols_cfg = SIZE_RESET;
            expected_products.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_products.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d/%0b with no request waiting",
                                              product_value, index_error));
                end
                else
                begin
                    want = expected_products.pop_front();
                    products_checked++;
                    if (want.index_error)
                    begin
                        error_results++;
                    end
                    if (product_value !== want.value)
                    begin
                        report_mismatch($sformatf("product_value expected %0d, got %0d",
                                                  $signed(want.value), product_value));
                    end
                    if (index_error !== want.index_error)
                    begin
                        report_mismatch($sformatf("index_error expected %0b, got %0b",
                                                  want.index_error, index_error));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                case (opcode)
                    OP_WRITE_A:   a_elems[row_index][col_index] = element_value;
                    OP_WRITE_B:   b_elems[row_index][col_index] = element_value;
                    OP_READ_PROD: expected_products.push_back(
                                      dot_product_element(row_index, col_index));
                    default:      ;
                endcase
            end
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
            begin
                if (paddr[2] == REG_ROWS_USED)
                begin
                    rows_cfg = pwdata[CFG_W-1:0];
                end
                else
                begin
                    cols_cfg = pwdata[CFG_W-1:0];
                end
            end
            pending <= expected_products.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the matrix multiply engine: drives requests and size writes, gives the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mme_pkg::*;

    localparam logic [1:0] OP_UNUSED        = 2'd3;
    localparam int         NUM_PHASES       = 9;
    localparam int         RANDOM_PER_PHASE = 135;
    localparam int         SETTLE_CYCLES    = 32;
    localparam int         CYCLE_LIMIT      = 400000;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      in_valid      = 1'b0;
    logic                      in_ready;
    logic [1:0]                opcode        = '0;
    logic [IDX_W-1:0]          row_index     = '0;
    logic [IDX_W-1:0]          col_index     = '0;
    logic signed [ELEM_W-1:0]  element_value = '0;
    logic                      out_valid;
    logic                      out_ready     = 1'b0;
    logic signed [PROD_W-1:0]  product_value;
    logic                      index_error;
    logic                      psel          = 1'b0;
    logic                      penable       = 1'b0;
    logic                      pwrite        = 1'b0;
    logic [PADDR_W-1:0]        paddr         = '0;
    logic [PDATA_W-1:0]        pwdata        = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    int fail_count;
    int pending;
    int products_checked;
    int error_results;

    int cycle_count   = 0;
    int stall_pct     = 0;
    int send_idle_pct = 0;
    int random_left   = 0;
    int requests_sent = 0;
    int rows_cfg      = 16;
    int cols_cfg      = 16;
    int rows_tab [NUM_PHASES] = '{16, 16, 1, 0, 31, 9, 17, 0, 3};
    int cols_tab [NUM_PHASES] = '{1, 16, 16, 7, 31, 0, 4, 0, 2};
    bit a_written [MAX_DIM][MAX_DIM];
    bit b_written [MAX_DIM][MAX_DIM];

    matrix_multiply_engine_top i_dut (.*);

    mme_product_checker i_checker (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** matrix_multiply_engine_top: FAILED **");
            $finish;
        end
    end

    function automatic int eff_rows();
        return (rows_cfg > MAX_DIM) ? MAX_DIM : rows_cfg;
    endfunction

    function automatic int eff_cols();
        return (cols_cfg > MAX_DIM) ? MAX_DIM : cols_cfg;
    endfunction

    function automatic logic signed [ELEM_W-1:0] random_element();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return $urandom_range(0, 1) ? 16'sh0000 : 16'shffff;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic bit operands_written(input int row, input int col);
        int k;
        for (k = 0; k < eff_cols(); k++)
        begin
            if (!a_written[row][k] || !b_written[k][col])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_size_reg(input logic reg_idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (reg_idx == REG_ROWS_USED)
        begin
            rows_cfg = value;
        end
        else
        begin
            cols_cfg = value;
        end
    endtask

    task automatic send_request(input logic [1:0] op, input int row, input int col,
                                input logic signed [ELEM_W-1:0] val);
        if ($urandom_range(0, 199) == 0)
        begin
            wait_results_drained();
        end
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        row_index     <= IDX_W'(row);
        col_index     <= IDX_W'(col);
        element_value <= val;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        requests_sent++;
        if (op == OP_WRITE_A)
        begin
            a_written[row][col] = 1'b1;
        end
        else if (op == OP_WRITE_B)
        begin
            b_written[row][col] = 1'b1;
        end
        if (op != OP_UNUSED && random_left > 0)
        begin
            random_left--;
        end
    endtask

    task automatic read_with_operands(input int row, input int col);
        int                       nc;
        int                       pick;
        int                       k;
        logic signed [ELEM_W-1:0] fill_a;
        logic signed [ELEM_W-1:0] fill_b;
        nc = eff_cols();
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            fill_a = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
            fill_b = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
            for (k = 0; k < nc; k++)
            begin
                send_request(OP_WRITE_A, row, k, fill_a);
                send_request(OP_WRITE_B, k, col, fill_b);
            end
        end
        else
        begin
            for (k = 0; k < nc; k++)
            begin
                if (!a_written[row][k])
                begin
                    send_request(OP_WRITE_A, row, k, random_element());
                end
                if (!b_written[k][col])
                begin
                    send_request(OP_WRITE_B, k, col, random_element());
                end
            end
            if (pick <= 4)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    k = $urandom_range(0, nc - 1);
                    if ($urandom_range(0, 1))
                    begin
                        send_request(OP_WRITE_A, row, k, random_element());
                    end
                    else
                    begin
                        send_request(OP_WRITE_B, k, col, random_element());
                    end
                end
            end
        end
        send_request(OP_READ_PROD, row, col, random_element());
    endtask

    task automatic random_item();
        int nr;
        int nc;
        int pick;
        int row;
        int col;
        nr = eff_rows();
        nc = eff_cols();
        pick = $urandom_range(0, 99);
        row = $urandom_range(0, MAX_DIM - 1);
        col = $urandom_range(0, MAX_DIM - 1);
        if (pick < 70)
        begin
            if (nr == 0 || nc == 0)
            begin
                send_request(OP_READ_PROD, row, col, random_element());
            end
            else
            begin
                read_with_operands($urandom_range(0, nr - 1), $urandom_range(0, nc - 1));
            end
        end
        else if (pick < 80)
        begin
            send_request($urandom_range(0, 1) ? OP_WRITE_A : OP_WRITE_B, row, col,
                         random_element());
        end
        else if (pick < 85)
        begin
            send_request(OP_UNUSED, row, col, random_element());
        end
        else
        begin
            if (nr < MAX_DIM && $urandom_range(0, 1))
            begin
                row = $urandom_range(nr, MAX_DIM - 1);
            end
            else if (nc < MAX_DIM)
            begin
                col = $urandom_range(nc, MAX_DIM - 1);
            end
            if (row >= nr || col >= nc || operands_written(row, col))
            begin
                send_request(OP_READ_PROD, row, col, random_element());
            end
            else
            begin
                send_request(OP_WRITE_A, row, col, random_element());
            end
        end
    endtask

    initial
    begin
        int phase;
        rows_tab[7] = $urandom_range(0, 31);
        cols_tab[7] = $urandom_range(0, 31);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1:
                begin
                    send_idle_pct = 51;
                    stall_pct    <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 51;
                end
                default:
                begin
                    send_idle_pct = 6;
                    stall_pct    <= 6;
                end
            endcase
            write_size_reg(REG_ROWS_USED, rows_tab[phase]);
            write_size_reg(REG_COLS_USED, cols_tab[phase]);
            if (phase == 0)
            begin
                send_request(OP_WRITE_A, 0, 0, 16'sh8000);
                send_request(OP_WRITE_B, 0, 0, 16'sh8000);
                send_request(OP_READ_PROD, 0, 0, 16'sh7fff);
                send_request(OP_WRITE_A, 15, 0, 16'sh7fff);
                send_request(OP_READ_PROD, 15, 0, 16'sh0000);
                send_request(OP_WRITE_B, 0, 0, 16'sh7fff);
                send_request(OP_READ_PROD, 15, 0, 16'shffff);
                send_request(OP_READ_PROD, 0, 0, 16'sh0000);
                send_request(OP_READ_PROD, 0, 1, 16'sh0000);
                send_request(OP_READ_PROD, 15, 15, 16'sh5555);
                send_request(OP_UNUSED, 0, 0, 16'sh1234);
                send_request(OP_UNUSED, 15, 15, 16'sh8000);
                send_request(OP_READ_PROD, 0, 0, 16'sh0000);
                send_request(OP_WRITE_A, 15, 15, 16'shffff);
                send_request(OP_WRITE_B, 15, 15, 16'sh5555);
                send_request(OP_WRITE_A, 7, 0, 16'sh0001);
                send_request(OP_READ_PROD, 7, 0, 16'sh8000);
            end
            random_left = RANDOM_PER_PHASE;
            while (random_left > 0)
            begin
                random_item();
            end
            wait_results_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        $display("Sent %0d requests over %0d size settings and four idle patterns;",
                 requests_sent, NUM_PHASES);
        $display("checked %0d product results, %0d of them index errors.",
                 products_checked, error_results);
        if (fail_count == 0)
        begin
            $display("** matrix_multiply_engine_top: PASSED **");
        end
        else
        begin
            $display("** matrix_multiply_engine_top: FAILED **");
        end
        $finish;
    end

endmodule
